FILE: hdl/i2c_master_byte_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// I2C master byte sequencer - assertion macros
// Shared concurrent assertion forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_UNIT_DEFINES_SVH

// clocked on clk, quiet while arst_n is low
`define I2CMBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked on clk, checked through reset too
`define I2CMBS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/i2cmbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer - package
// Command codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

	localparam int unsigned OP_W      = 3;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned PHASE_W   = 16;
	localparam int unsigned POLL_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// commands
	localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
	localparam logic [OP_W-1:0] OP_START    = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_ACK = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_NAK = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

	localparam logic [PHASE_W-1:0] PHASE_TICKS_RST    = 16'd5;
	localparam logic [POLL_W-1:0]  ACK_POLL_LIMIT_RST = 8'd50;

endpackage

FILE: hdl/i2c_master_byte_sequencer_unit.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer
// Tick-driven I2C master: start, stop, byte write with ack poll, byte read
// with ack or nak. Each accepted word is one bus timing tick.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | operation, write_byte, sda_sample
//  out     | out_valid / out_ready| scl_level, sda_level, sda_drive_enable,
//          |                      | busy_res, done_res, read_data, ack_seen
//  cfg     | cfg_we (no wait)     | cfg_index, cfg_data
//
//  One word in per clock while the output is not stalled, one word out per word in;
//  a word's result is registered and shows in the cycle after it is accepted.
//  The sequencer state registers double as the result register, so a result
//  is held for as long as out_ready stays low; in_ready follows the output slot (empty, or drained in the same cycle).
//  arst_n clears the sequencer to bus idle: SCL high, SDA released, latched
//  SDA high, phase_ticks 5, ack_poll_limit 50.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_unit
	import i2cmbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OP_W-1:0]       operation,
	input  logic [BYTE_W-1:0]     write_byte,
	input  logic                  sda_sample,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  scl_level,
	output logic                  sda_level,
	output logic                  sda_drive_enable,
	output logic                  busy_res,
	output logic                  done_res,
	output logic [BYTE_W-1:0]     read_data,
	output logic                  ack_seen,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_STOP,
		ST_WBIT,
		ST_WACK,
		ST_RBIT,
		ST_RACK
	} seq_state_t;

	// configuration
	logic [PHASE_W-1:0] phase_ticks_q;
	logic [POLL_W-1:0]  ack_poll_limit_q;

	// sequencer state (also the visible result)
	seq_state_t         state_q,  state_d;
	logic [PHASE_W-1:0] phase_q,  phase_d;
	logic [1:0]         sub_q,    sub_d;
	logic [2:0]         bit_q,    bit_d;
	logic [BYTE_W-1:0]  shift_q,  shift_d;
	logic [POLL_W-1:0]  poll_q,   poll_d;
	logic               ack_q,    ack_d;
	logic               nak_q,    nak_d;
	logic               scl_q,    scl_d;
	logic               sda_q,    sda_d;
	logic               oe_q,     oe_d;
	logic [BYTE_W-1:0]  read_q,   read_d;
	logic               done_q,   done_d;
	logic               out_valid_q;

	logic [PHASE_W-1:0] phase_load;
	logic               in_acc;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	// a zero phase length behaves as one tick
	assign phase_load = (phase_ticks_q == '0) ? PHASE_W'(1) : phase_ticks_q;

	// ---- next state for one tick ----
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		sub_d   = sub_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		poll_d  = poll_q;
		ack_d   = ack_q;
		nak_d   = nak_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		oe_d    = oe_q;
		read_d  = read_q;
		done_d  = 1'b0;

		if (state_q == ST_IDLE) begin
			// idle: pick up a command, if any
			bit_d = '0;
			sub_d = '0;
			unique case (operation)
				OP_START: begin
					state_d = ST_START;
					oe_d    = 1'b1;
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					phase_d = phase_load;
				end
				OP_STOP: begin
					state_d = ST_STOP;
					oe_d    = 1'b1;
					sda_d   = 1'b0;
					scl_d   = 1'b1;
					phase_d = phase_load;
				end
				OP_WRITE: begin
					state_d = ST_WBIT;
					ack_d   = 1'b0;
					oe_d    = 1'b1;
					sda_d   = write_byte[BYTE_W-1];
					shift_d = {write_byte[BYTE_W-2:0], 1'b0};
					phase_d = phase_load;
				end
				OP_READ_ACK, OP_READ_NAK: begin
					state_d = ST_RBIT;
					nak_d   = (operation == OP_READ_NAK);
					oe_d    = 1'b0;
					shift_d = '0;
					phase_d = phase_load;
				end
				default: begin
				end
			endcase
		end else if (phase_q > PHASE_W'(1)) begin
			phase_d = phase_q - PHASE_W'(1);
		end else begin
			// phase over: step the sequence; default is load the next phase
			phase_d = phase_load;
			unique case (state_q)
				ST_START: begin
					if (sub_q == 2'd0) begin
						sda_d = 1'b0;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						scl_d = 1'b0;
						sub_d = 2'd2;
					end else begin
						state_d = ST_IDLE;
						sub_d   = '0;
						phase_d = '0;
						done_d  = 1'b1;
					end
				end
				ST_STOP: begin
					if (sub_q == 2'd0) begin
						sda_d = 1'b1;
						sub_d = 2'd1;
					end else begin
						oe_d    = 1'b0;
						state_d = ST_IDLE;
						sub_d   = '0;
						phase_d = '0;
						done_d  = 1'b1;
					end
				end
				ST_WBIT: begin
					if (sub_q == 2'd0) begin
						scl_d = 1'b1;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						scl_d = 1'b0;
						sub_d = 2'd2;
					end else if (bit_q != 3'd7) begin
						bit_d   = bit_q + 3'd1;
						sda_d   = shift_q[BYTE_W-1];
						shift_d = {shift_q[BYTE_W-2:0], 1'b0};
						sub_d   = 2'd0;
					end else begin
						state_d = ST_WACK;
						oe_d    = 1'b0;
						sda_d   = 1'b1;
						sub_d   = 2'd0;
					end
				end
				ST_WACK: begin
					if (sub_q == 2'd0) begin
						scl_d  = 1'b1;
						poll_d = '0;
						sub_d  = 2'd1;
					end else if (sub_q == 2'd1) begin
						// poll the ack at each phase end, up to the limit
						if (poll_q < ack_poll_limit_q) begin
							if (!sda_sample) begin
								ack_d = 1'b1;
								scl_d = 1'b0;
								sub_d = 2'd2;
							end else begin
								poll_d = poll_q + POLL_W'(1);
							end
						end else begin
							scl_d = 1'b0;
							sub_d = 2'd2;
						end
					end else begin
						oe_d    = 1'b1;
						state_d = ST_IDLE;
						sub_d   = '0;
						phase_d = '0;
						done_d  = 1'b1;
					end
				end
				ST_RBIT: begin
					if (sub_q == 2'd0) begin
						scl_d = 1'b1;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						shift_d = {shift_q[BYTE_W-2:0], sda_sample};
						scl_d   = 1'b0;
						sub_d   = 2'd2;
					end else if (bit_q != 3'd7) begin
						bit_d = bit_q + 3'd1;
						sub_d = 2'd0;
					end else begin
						read_d  = shift_q;
						state_d = ST_RACK;
						oe_d    = 1'b1;
						sda_d   = nak_q;
						sub_d   = 2'd0;
					end
				end
				ST_RACK: begin
					if (sub_q == 2'd0) begin
						scl_d = 1'b1;
						sub_d = 2'd1;
					end else if (sub_q == 2'd1) begin
						scl_d = 1'b0;
						sub_d = 2'd2;
					end else begin
						state_d = ST_IDLE;
						sub_d   = '0;
						phase_d = '0;
						done_d  = 1'b1;
					end
				end
				default: begin
					state_d = ST_IDLE;
					sub_d   = '0;
					phase_d = '0;
					done_d  = 1'b1;
				end
			endcase
		end
	end

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q    <= PHASE_TICKS_RST;
			ack_poll_limit_q <= ACK_POLL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_TICKS:    phase_ticks_q    <= cfg_data;
				CFG_ACK_POLL_LIMIT: ack_poll_limit_q <= cfg_data[POLL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---- sequencer state and result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			sub_q       <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			poll_q      <= '0;
			ack_q       <= 1'b0;
			nak_q       <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			oe_q        <= 1'b0;
			read_q      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				state_q <= state_d;
				phase_q <= phase_d;
				sub_q   <= sub_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				poll_q  <= poll_d;
				ack_q   <= ack_d;
				nak_q   <= nak_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
				oe_q    <= oe_d;
				read_q  <= read_d;
				done_q  <= done_d;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign scl_level        = scl_q;
	assign sda_level        = sda_q;
	assign sda_drive_enable = oe_q;
	assign busy_res         = (state_q != ST_IDLE);
	assign done_res         = done_q;
	assign read_data        = read_q;
	assign ack_seen         = ack_q;

endmodule

FILE: hdl/i2cmbs_checker.sv
// ----------------------------------------------------------------------------
// I2C master byte sequencer - port checker
// Watches the top-level ports; bound to the sequencer below.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_sequencer_unit_defines.svh"

module i2cmbs_checker
	import i2cmbs_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [OP_W-1:0]       operation,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  scl_level,
	input logic                  sda_level,
	input logic                  sda_drive_enable,
	input logic                  busy_res,
	input logic                  done_res,
	input logic [BYTE_W-1:0]     read_data
);

	// a stalled result holds
	`I2CMBS_ASSERT(a_out_hold,
		out_valid && !out_ready |=> out_valid && $stable(read_data) &&
		$stable(done_res) && $stable(scl_level),
		"result changed while stalled")

	// finishing a command leaves the sequencer idle
	`I2CMBS_ASSERT_ALWAYS(a_done_idle, done_res |-> !busy_res, "done shown while busy")

	// start from idle: bus held high, SDA driven
	`I2CMBS_ASSERT(a_start,
		in_valid && in_ready && !busy_res && operation == OP_START |=>
		busy_res && scl_level && sda_level && sda_drive_enable,
		"start did not begin")

	// read from idle releases SDA
	`I2CMBS_ASSERT(a_read,
		in_valid && in_ready && !busy_res &&
		(operation == OP_READ_ACK || operation == OP_READ_NAK) |=>
		busy_res && !sda_drive_enable,
		"read did not release SDA")

endmodule

bind i2c_master_byte_sequencer_unit i2cmbs_checker u_i2cmbs_checker (.*);
